### sv/mlt_pkg.sv
// Shared types, constants and the bucket hash for the MAC learning table.
// No dependencies; every other file in the project uses this package.
`default_nettype none

package mlt_pkg;

    // Parameter defaults.
    localparam int BUCKETS_DEF = 256;
    localparam int WAYS_DEF    = 4;
    localparam int PORTS_DEF   = 16;

    // Field widths.
    localparam int MAC_W     = 48;
    localparam int PORT_W    = 4;
    localparam int STAMP_W   = 16;
    localparam int LIMIT_W   = 15;
    localparam int DEC_W     = 2;
    localparam int BKT_W_MAX = 12;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd8;
    localparam logic [MAC_W-1:0]   BCAST_MAC   = 48'hFFFF_FFFF_FFFF;

    // Item opcodes.
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [DEC_W-1:0] {
        DEC_BCAST = 2'd0,
        DEC_FWD   = 2'd1,
        DEC_FLOOD = 2'd2
    } dec_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_LEARN,
        ST_LOOK,
        ST_SWEEP
    } st_t;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        logic                 is_tick;
        logic                 learn_en;
        logic                 is_bcast;
        logic [MAC_W-1:0]     src_mac;
        logic [MAC_W-1:0]     dst_mac;
        logic [PORT_W-1:0]    port;
        logic [BKT_W_MAX-1:0] src_bkt;
        logic [BKT_W_MAX-1:0] dst_bkt;
    } cmd_t;

    // Hash h = h*31 + byte over the six bytes, first byte first. Only the low
    // bits survive the reduction by a power-of-two bucket count, so the sum is
    // kept at the widest bucket index.
    function automatic logic [BKT_W_MAX-1:0] mac_hash(input logic [MAC_W-1:0] mac);
        logic [BKT_W_MAX-1:0] h;
        h = '0;
        for (int i = 0; i < 6; i++) begin
            h = (h << 5) - h + BKT_W_MAX'(mac[MAC_W-1-8*i -: 8]);
        end
        return h;
    endfunction

endpackage

`default_nettype wire

### sv/mac_learning_table_with_aging.sv
// Top level of the MAC learning table: aging register, front end, queue and
// back end. Depends on mlt_pkg, mlt_front, mlt_queue and mlt_back.
//
//   Channel | Direction | Handshake         | Payload
//   s_      | in        | s_valid/s_ready   | opcode, src_mac, dst_mac, in_port
//   m_      | out       | m_valid/m_ready   | decision, out_port
//   cfg_    | in        | cfg_valid/cfg_ready | aging_limit (15 bits)
//
// A frame passes through the back end as a source row read, a learn write with
// destination read, then a lookup into the result register once it is free.
// A tick sweeps the table one row per cycle, writing back the row read before.
// After reset a clearing pass writes every row; s_ready is low meanwhile.
// A two-entry queue lets the front keep accepting while the result waits.
// BUCKETS must be a power of two.
`default_nettype none

module mac_learning_table_with_aging #(
    parameter int BUCKETS = mlt_pkg::BUCKETS_DEF,
    parameter int WAYS    = mlt_pkg::WAYS_DEF,
    parameter int PORTS   = mlt_pkg::PORTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_opcode,
    input  wire logic [mlt_pkg::MAC_W-1:0]     s_src_mac,
    input  wire logic [mlt_pkg::MAC_W-1:0]     s_dst_mac,
    input  wire logic [mlt_pkg::PORT_W-1:0]    s_in_port,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [mlt_pkg::DEC_W-1:0]          m_decision,
    output logic [mlt_pkg::PORT_W-1:0]         m_out_port,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mlt_pkg::LIMIT_W-1:0]   cfg_data
);

    logic [mlt_pkg::LIMIT_W-1:0] limit_reg;
    logic                        init_busy;
    logic                        q_push, q_full, q_pop, q_empty;
    mlt_pkg::cmd_t               q_in, q_out;

    // The configuration register takes every transfer.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= mlt_pkg::LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    mlt_front #(
        .BUCKETS (BUCKETS),
        .PORTS   (PORTS)
    ) u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .s_src_mac (s_src_mac),
        .s_dst_mac (s_dst_mac),
        .s_in_port (s_in_port),
        .init_busy (init_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_in)
    );

    mlt_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_out),
        .empty   (q_empty)
    );

    mlt_back #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_cmd       (q_out),
        .q_pop       (q_pop),
        .aging_limit (limit_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_decision  (m_decision),
        .m_out_port  (m_out_port),
        .init_busy   (init_busy)
    );

    // No item is taken while the table is being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn) init_busy |-> !s_ready)
        else $error("item accepted during clearing pass");

    // The queue is never written when full.
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_full)
        else $error("queue overflow");

    // The back end pops only a queue that holds a command.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_empty)
        else $error("queue underflow");

endmodule

`default_nettype wire

### sv/mlt_front.sv
// Front end: accepts input items, hashes both addresses and classifies them.
// Depends on mlt_pkg.
`default_nettype none

module mlt_front #(
    parameter int BUCKETS = mlt_pkg::BUCKETS_DEF,
    parameter int PORTS   = mlt_pkg::PORTS_DEF
) (
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_opcode,
    input  wire logic [mlt_pkg::MAC_W-1:0]   s_src_mac,
    input  wire logic [mlt_pkg::MAC_W-1:0]   s_dst_mac,
    input  wire logic [mlt_pkg::PORT_W-1:0]  s_in_port,
    input  wire logic                        init_busy,
    input  wire logic                        q_full,
    output logic                             q_push,
    output mlt_pkg::cmd_t                    q_cmd
);

    localparam logic [mlt_pkg::BKT_W_MAX-1:0] BKT_MASK =
        mlt_pkg::BKT_W_MAX'(BUCKETS - 1);

    // Items are taken only when the queue has room and the table is cleared.
    assign s_ready = !q_full && !init_busy;
    assign q_push  = s_valid && s_ready;

    // Classify the item and reduce both hashes to bucket indexes.
    always_comb begin
        q_cmd          = '0;
        q_cmd.is_tick  = (s_opcode == mlt_pkg::OP_TICK);
        q_cmd.learn_en = (32'(s_in_port) < 32'(PORTS));
        q_cmd.is_bcast = (s_dst_mac == mlt_pkg::BCAST_MAC);
        q_cmd.src_mac  = s_src_mac;
        q_cmd.dst_mac  = s_dst_mac;
        q_cmd.port     = s_in_port;
        q_cmd.src_bkt  = mlt_pkg::mac_hash(s_src_mac) & BKT_MASK;
        q_cmd.dst_bkt  = mlt_pkg::mac_hash(s_dst_mac) & BKT_MASK;
    end

endmodule

`default_nettype wire

### sv/mlt_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on mlt_pkg.
`default_nettype none

module mlt_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire mlt_pkg::cmd_t din,
    output logic               full,
    input  wire logic          pop,
    output mlt_pkg::cmd_t      dout,
    output logic               empty
);

    mlt_pkg::cmd_t data_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign dout  = data_reg[rd_ptr_reg];

    // Pointer and count update.
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

### sv/mlt_back.sv
// Back end: owns the table memory, learns sources, looks up destinations,
// runs the aging sweep and the clearing pass. Depends on mlt_pkg.
`default_nettype none

module mlt_back #(
    parameter int BUCKETS = mlt_pkg::BUCKETS_DEF,
    parameter int WAYS    = mlt_pkg::WAYS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_empty,
    input  wire mlt_pkg::cmd_t                 q_cmd,
    output logic                               q_pop,
    input  wire logic [mlt_pkg::LIMIT_W-1:0]   aging_limit,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [mlt_pkg::DEC_W-1:0]          m_decision,
    output logic [mlt_pkg::PORT_W-1:0]         m_out_port,
    output logic                               init_busy
);

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int CNT_W = BKT_W + 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int MW    = mlt_pkg::MAC_W;
    localparam int PW    = mlt_pkg::PORT_W;
    localparam int TW    = mlt_pkg::STAMP_W;

    // Table memory, one row per bucket.
    logic [WAYS-1:0]         valid_mem [BUCKETS];
    logic [WAYS-1:0][MW-1:0] mac_mem   [BUCKETS];
    logic [WAYS-1:0][PW-1:0] port_mem  [BUCKETS];
    logic [WAYS-1:0][TW-1:0] stamp_mem [BUCKETS];

    logic [WAYS-1:0]         rd_valid;
    logic [WAYS-1:0][MW-1:0] rd_mac;
    logic [WAYS-1:0][PW-1:0] rd_port;
    logic [WAYS-1:0][TW-1:0] rd_stamp;

    logic                    rd_en, wr_en;
    logic [BKT_W-1:0]        rd_addr, wr_addr;
    logic [WAYS-1:0]         wr_valid;
    logic [WAYS-1:0][MW-1:0] wr_mac;
    logic [WAYS-1:0][PW-1:0] wr_port;
    logic [WAYS-1:0][TW-1:0] wr_stamp;

    // Sequencer state.
    mlt_pkg::st_t   st_reg, st_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [TW-1:0]  now_reg, now_next;
    mlt_pkg::cmd_t  cmd_reg, cmd_next;

    // Learned row kept for a destination in the same bucket.
    logic [WAYS-1:0]         sv_valid_reg;
    logic [WAYS-1:0][MW-1:0] sv_mac_reg;
    logic [WAYS-1:0][PW-1:0] sv_port_reg;

    // Result register.
    logic                    m_valid_reg;
    logic [mlt_pkg::DEC_W-1:0] m_dec_reg;
    logic [PW-1:0]           m_port_reg;

    // Combinational results.
    logic [WAYS-1:0]         ln_valid;
    logic [WAYS-1:0][MW-1:0] ln_mac;
    logic [WAYS-1:0][PW-1:0] ln_port;
    logic [WAYS-1:0][TW-1:0] ln_stamp;
    logic [WAYS-1:0]         sw_valid;
    logic                    lk_hit;
    logic [PW-1:0]           lk_port;
    logic                    out_load;
    mlt_pkg::dec_t           out_dec;
    logic [PW-1:0]           out_port;

    assign m_valid    = m_valid_reg;
    assign m_decision = m_dec_reg;
    assign m_out_port = m_port_reg;
    assign init_busy  = (st_reg == mlt_pkg::ST_INIT);

    // Memory write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            valid_mem[wr_addr] <= wr_valid;
            mac_mem[wr_addr]   <= wr_mac;
            port_mem[wr_addr]  <= wr_port;
            stamp_mem[wr_addr] <= wr_stamp;
        end
        if (rd_en) begin
            rd_valid <= valid_mem[rd_addr];
            rd_mac   <= mac_mem[rd_addr];
            rd_port  <= port_mem[rd_addr];
            rd_stamp <= stamp_mem[rd_addr];
        end
    end

    // Learning: refresh a matching way, else fill the first free way, else
    // replace the oldest way, the lowest one on a tie.
    always_comb begin
        logic             hit, free;
        logic [WAY_W-1:0] hit_way, free_way, old_way, pick;
        logic [TW-1:0]    age, oldest;
        hit      = 1'b0;
        free     = 1'b0;
        hit_way  = '0;
        free_way = '0;
        old_way  = '0;
        oldest   = '0;
        for (int w = 0; w < WAYS; w++) begin
            age = now_reg - rd_stamp[w];
            if (!hit && rd_valid[w] && rd_mac[w] == cmd_reg.src_mac) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!free && !rd_valid[w]) begin
                free     = 1'b1;
                free_way = WAY_W'(w);
            end
            if (w == 0 || age > oldest) begin
                oldest  = age;
                old_way = WAY_W'(w);
            end
        end
        pick = hit ? hit_way : (free ? free_way : old_way);
        ln_valid       = rd_valid;
        ln_mac         = rd_mac;
        ln_port        = rd_port;
        ln_stamp       = rd_stamp;
        ln_valid[pick] = 1'b1;
        ln_mac[pick]   = cmd_reg.src_mac;
        ln_port[pick]  = cmd_reg.port;
        ln_stamp[pick] = now_reg;
    end

    // Aging: drop entries older than the limit.
    always_comb begin
        logic [TW-1:0] age;
        for (int w = 0; w < WAYS; w++) begin
            age         = now_reg - rd_stamp[w];
            sw_valid[w] = rd_valid[w] && !(age > {1'b0, aging_limit});
        end
    end

    // Destination lookup, taking the just-learned row when the buckets match.
    always_comb begin
        logic                    same;
        logic [WAYS-1:0]         lv;
        logic [WAYS-1:0][MW-1:0] lm;
        logic [WAYS-1:0][PW-1:0] lp;
        same    = cmd_reg.learn_en && (cmd_reg.src_bkt == cmd_reg.dst_bkt);
        lv      = same ? sv_valid_reg : rd_valid;
        lm      = same ? sv_mac_reg : rd_mac;
        lp      = same ? sv_port_reg : rd_port;
        lk_hit  = 1'b0;
        lk_port = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!lk_hit && lv[w] && lm[w] == cmd_reg.dst_mac) begin
                lk_hit  = 1'b1;
                lk_port = lp[w];
            end
        end
        if (cmd_reg.is_bcast) begin
            out_dec  = mlt_pkg::DEC_BCAST;
            out_port = '0;
        end else if (lk_hit) begin
            out_dec  = mlt_pkg::DEC_FWD;
            out_port = lk_port;
        end else begin
            out_dec  = mlt_pkg::DEC_FLOOD;
            out_port = '0;
        end
    end

    // Sequencer outputs: memory ports, queue pop and result load.
    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = cmd_reg.src_bkt[BKT_W-1:0];
        wr_valid = ln_valid;
        wr_mac   = ln_mac;
        wr_port  = ln_port;
        wr_stamp = ln_stamp;
        q_pop    = 1'b0;
        out_load = 1'b0;
        case (st_reg)
            mlt_pkg::ST_INIT: begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg[BKT_W-1:0];
                wr_valid = '0;
            end
            mlt_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    q_pop   = 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = q_cmd.is_tick ? '0 : q_cmd.src_bkt[BKT_W-1:0];
                end
            end
            mlt_pkg::ST_LEARN: begin
                wr_en   = cmd_reg.learn_en;
                rd_en   = 1'b1;
                rd_addr = cmd_reg.dst_bkt[BKT_W-1:0];
            end
            mlt_pkg::ST_LOOK: begin
                out_load = !m_valid_reg || m_ready;
            end
            mlt_pkg::ST_SWEEP: begin
                wr_en    = 1'b1;
                wr_addr  = BKT_W'(cnt_reg - CNT_W'(1));
                wr_valid = sw_valid;
                wr_mac   = rd_mac;
                wr_port  = rd_port;
                wr_stamp = rd_stamp;
                if (cnt_reg != CNT_W'(BUCKETS)) begin
                    rd_en   = 1'b1;
                    rd_addr = cnt_reg[BKT_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        now_next = now_reg;
        cmd_next = cmd_reg;
        case (st_reg)
            mlt_pkg::ST_INIT: begin
                if (cnt_reg == CNT_W'(BUCKETS - 1)) begin
                    cnt_next = '0;
                    st_next  = mlt_pkg::ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            mlt_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    cmd_next = q_cmd;
                    if (q_cmd.is_tick) begin
                        now_next = now_reg + TW'(1);
                        cnt_next = CNT_W'(1);
                        st_next  = mlt_pkg::ST_SWEEP;
                    end else begin
                        st_next = mlt_pkg::ST_LEARN;
                    end
                end
            end
            mlt_pkg::ST_LEARN: begin
                st_next = mlt_pkg::ST_LOOK;
            end
            mlt_pkg::ST_LOOK: begin
                if (out_load) begin
                    st_next = mlt_pkg::ST_IDLE;
                end
            end
            mlt_pkg::ST_SWEEP: begin
                if (cnt_reg == CNT_W'(BUCKETS)) begin
                    cnt_next = '0;
                    st_next  = mlt_pkg::ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default: begin
                st_next = mlt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= mlt_pkg::ST_INIT;
            cnt_reg     <= '0;
            now_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            now_reg <= now_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        if (st_reg == mlt_pkg::ST_LEARN) begin
            sv_valid_reg <= ln_valid;
            sv_mac_reg   <= ln_mac;
            sv_port_reg  <= ln_port;
        end
        if (out_load) begin
            m_dec_reg  <= out_dec;
            m_port_reg <= out_port;
        end
    end

endmodule

`default_nettype wire
